// ----- design/sem_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies.
package sem_pkg;
    localparam int MaxWidth  = 2048;
    localparam int MaxHeight = 2048;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int PosW      = 12;
    localparam int CfgW      = 12;

    localparam logic [0:0] CfgFrameWidth  = 1'b0;
    localparam logic [0:0] CfgFrameHeight = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_SQRT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic shift_win;
        logic sqrt_start;
        logic restart;
    } cmd_t;

    typedef struct packed {
        logic drop_item;
        logic emit;
        logic sqrt_done;
    } status_t;
endpackage

// ----- design/sem_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences one word through read, window shift, root and output; a word may end after read or shift.
// Depends on sem_pkg.
module sem_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_fire,
    input  sem_pkg::status_t  status,
    output sem_pkg::cmd_t     cmd,
    output logic              in_busy,
    output logic              out_full
);
    sem_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sem_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_busy        = 1'b1;
        out_full       = 1'b0;
        unique case (state_reg)
            sem_pkg::ST_IDLE:
            begin
                in_busy = 1'b0;
                if (in_fire)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = sem_pkg::ST_READ;
                end
            end
            sem_pkg::ST_READ:
            begin
                if (status.drop_item)
                begin
                    state_next = sem_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = sem_pkg::ST_SHIFT;
                end
            end
            sem_pkg::ST_SHIFT:
            begin
                cmd.shift_win = 1'b1;
                if (status.emit)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = sem_pkg::ST_SQRT;
                end
                else
                begin
                    state_next = sem_pkg::ST_IDLE;
                end
            end
            sem_pkg::ST_SQRT:
            begin
                if (status.sqrt_done)
                begin
                    state_next = sem_pkg::ST_OUT;
                end
            end
            sem_pkg::ST_OUT:
            begin
                out_full = 1'b1;
                if (out_fire)
                begin
                    cmd.restart = 1'b1;
                    state_next  = sem_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sem_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// ----- design/sem_dp.sv -----
`timescale 1ns / 1ps
// Datapath: line stores, window, Sobel sums, serial rounded root per channel.
// Depends on sem_pkg.
module sem_dp
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_idx,
    input  logic [sem_pkg::CfgW-1:0]  cfg_data,
    input  logic                      in_cmd,
    input  logic [23:0]               in_pix,
    input  sem_pkg::cmd_t             cmd,
    output sem_pkg::status_t          status,
    output logic [23:0]               edges,
    output logic                      last
);
    localparam int ColW = sem_pkg::ColW;
    localparam int PosW = sem_pkg::PosW;
    // step 0 loads the radicand, steps 1..11 take two bits each
    localparam logic [3:0] StepDone = 4'd12;

    logic [23:0] upper_mem [sem_pkg::MaxWidth];
    logic [23:0] mid_mem   [sem_pkg::MaxWidth];

    logic [PosW-1:0] width_reg, height_reg;
    logic [ColW-1:0] in_col_reg;
    logic [PosW-1:0] in_row_reg, out_col_reg, out_row_reg, lead_reg;
    logic [23:0]     win_reg [9];
    logic [23:0]     pix_reg, up_reg, mid_reg;
    logic            flush_reg, last_reg;
    logic [3:0]      mask_reg;

    logic [PosW-1:0] cfg_clamped;
    logic [PosW-1:0] cfg_max;
    logic            frame_done;
    logic            emit;

    assign frame_done = (in_row_reg >= height_reg);
    assign status.drop_item = flush_reg ? !frame_done : frame_done;
    assign emit = (lead_reg >= width_reg + PosW'(1));
    assign status.emit = emit;

    always_comb
    begin
        cfg_max = (cfg_idx == sem_pkg::CfgFrameWidth) ? PosW'(sem_pkg::MaxWidth)
                                                      : PosW'(sem_pkg::MaxHeight);
        cfg_clamped = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_clamped = PosW'(1);
        end
        else if (cfg_data > cfg_max)
        begin
            cfg_clamped = cfg_max;
        end
    end

    // line stores: read on load, write back in shift
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            up_reg  <= upper_mem[in_col_reg];
            mid_reg <= mid_mem[in_col_reg];
            pix_reg <= in_cmd ? 24'd0 : in_pix;
            flush_reg <= in_cmd;
        end
        if (cmd.shift_win)
        begin
            upper_mem[in_col_reg] <= mid_reg;
            mid_mem[in_col_reg]   <= pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= PosW'(640);
            height_reg  <= PosW'(480);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lead_reg    <= '0;
            last_reg    <= 1'b0;
            mask_reg    <= '0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cfg_we || cmd.restart)
        begin
            if (cfg_we)
            begin
                if (cfg_idx == sem_pkg::CfgFrameWidth)
                begin
                    width_reg <= cfg_clamped;
                end
                else
                begin
                    height_reg <= cfg_clamped;
                end
            end
            if (cfg_we || last_reg)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                lead_reg    <= '0;
                last_reg    <= 1'b0;
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
        end
        else if (cmd.shift_win)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]   <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2] <= up_reg;
            win_reg[5] <= mid_reg;
            win_reg[8] <= pix_reg;
            if ({1'b0, in_col_reg} + PosW'(1) >= width_reg)
            begin
                in_col_reg <= '0;
                if (!frame_done)
                begin
                    in_row_reg <= in_row_reg + PosW'(1);
                end
            end
            else
            begin
                in_col_reg <= in_col_reg + ColW'(1);
            end
            if (!emit)
            begin
                lead_reg <= lead_reg + PosW'(1);
            end
            else
            begin
                // border masks for the result position
                mask_reg[0] <= (out_col_reg == '0);
                mask_reg[1] <= (out_col_reg + PosW'(1) >= width_reg);
                mask_reg[2] <= (out_row_reg == '0);
                mask_reg[3] <= (out_row_reg + PosW'(1) >= height_reg);
                if (out_col_reg + PosW'(1) >= width_reg)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + PosW'(1);
                    last_reg    <= (out_row_reg + PosW'(1) >= height_reg);
                end
                else
                begin
                    out_col_reg <= out_col_reg + PosW'(1);
                end
            end
        end
    end

    assign last = last_reg;

    // masked window per channel, from the shifted window, feeding the Sobel sums
    logic [23:0] cw [9];
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            cw[i] = win_reg[i];
        end
        if (mask_reg[0]) begin cw[0] = '0; cw[3] = '0; cw[6] = '0; end
        if (mask_reg[1]) begin cw[2] = '0; cw[5] = '0; cw[8] = '0; end
        if (mask_reg[2]) begin cw[0] = '0; cw[1] = '0; cw[2] = '0; end
        if (mask_reg[3]) begin cw[6] = '0; cw[7] = '0; cw[8] = '0; end
    end

    // serial root: gx/gy, then squares, then 11 two-bit steps over 22 bits
    logic [3:0]  step_reg;
    logic        busy_reg, sq_reg;
    logic [21:0] rad_reg  [3];
    logic [21:0] rem_reg  [3];
    logic [10:0] root_reg [3];
    logic signed [10:0] gx_reg [3];
    logic signed [10:0] gy_reg [3];

    assign status.sqrt_done = busy_reg && !sq_reg && (step_reg == StepDone);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sq_reg   <= 1'b0;
            step_reg <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            busy_reg <= 1'b1;
            sq_reg   <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            sq_reg <= 1'b0;
            if (!sq_reg)
            begin
                if (step_reg == StepDone)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + 4'd1;
                end
            end
        end
    end

    // cycle after start: gx/gy; next: squares; then root steps
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (cmd.sqrt_start)
            begin
                gx_reg[c] <= '0;
                gy_reg[c] <= '0;
            end
            if (sq_reg)
            begin
                gx_reg[c] <= (11'(cw[2][c*8+:8]) + 11'({cw[5][c*8+:8], 1'b0})
                    + 11'(cw[8][c*8+:8])) - (11'(cw[0][c*8+:8])
                    + 11'({cw[3][c*8+:8], 1'b0}) + 11'(cw[6][c*8+:8]));
                gy_reg[c] <= (11'(cw[6][c*8+:8]) + 11'({cw[7][c*8+:8], 1'b0})
                    + 11'(cw[8][c*8+:8])) - (11'(cw[0][c*8+:8])
                    + 11'({cw[1][c*8+:8], 1'b0}) + 11'(cw[2][c*8+:8]));
            end
            else if (busy_reg && step_reg == 4'd0)
            begin
                rad_reg[c]  <= 22'(gx_reg[c] * gx_reg[c])
                             + 22'(gy_reg[c] * gy_reg[c]);
                rem_reg[c]  <= '0;
                root_reg[c] <= '0;
            end
            else if (busy_reg && step_reg != StepDone)
            begin
                if ({rem_reg[c][19:0], rad_reg[c][21:20]} >=
                    {9'd0, root_reg[c], 2'b01})
                begin
                    rem_reg[c]  <= {rem_reg[c][19:0], rad_reg[c][21:20]}
                                 - {9'd0, root_reg[c], 2'b01};
                    root_reg[c] <= {root_reg[c][9:0], 1'b1};
                end
                else
                begin
                    rem_reg[c]  <= {rem_reg[c][19:0], rad_reg[c][21:20]};
                    root_reg[c] <= {root_reg[c][9:0], 1'b0};
                end
                rad_reg[c] <= {rad_reg[c][19:0], 2'b00};
            end
        end
    end

    // rounding: round up when remainder exceeds root; clamp to 255
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [11:0] r;
            r = {1'b0, root_reg[c]} + ((rem_reg[c] > {11'd0, root_reg[c]})
                ? 12'd1 : 12'd0);
            edges[c*8+:8] = (r > 12'd255) ? 8'd255 : r[7:0];
        end
    end
endmodule

// ----- design/sobel_edge_magnitude_rgb.sv -----
`timescale 1ns / 1ps
// Sobel 3x3 edge magnitude over an RGB raster stream.
// Depends on sem_pkg, sem_ctrl, sem_dp.
//
// Usage:
//   Input channel (valid/ready): one word per pixel in raster order; cmd=1
//   marks a flush word that carries no pixel and pushes trailing results.
//   Output channel (valid/ready): rounded, clamped Sobel magnitude of each
//   color; frame_last marks the final pixel of the frame.
//   The result of pixel k leaves with input word k + frame_width + 1.
//   Flow: each word is read, then shifts the window unless dropped; a word
//   that makes a result then runs the serial root (two bits per cycle over
//   a 22-bit radicand) and waits for the receiver. No new word is taken
//   until the current one is finished.
//   Config writes (frame_width, frame_height) are clamped to 1..2048 and
//   restart the frame. Write only while idle.
//   Reset: 640x480, positions cleared; line stores are not cleared, since
//   unwritten entries only feed masked border cells.
//   A stalled receiver holds the result; no new word is taken until the
//   result is taken.
module sobel_edge_magnitude_rgb
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_idx,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  pix_blue,
    input  logic [7:0]  pix_green,
    input  logic [7:0]  pix_red,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  edge_blue,
    output logic [7:0]  edge_green,
    output logic [7:0]  edge_red,
    output logic        frame_last
);
    sem_pkg::cmd_t    cmd_s;
    sem_pkg::status_t status_s;
    logic             in_busy;
    logic [23:0]      edges;

    assign in_ready = !in_busy;

    sem_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_valid && in_ready),
        .out_fire (out_valid && out_ready),
        .status   (status_s),
        .cmd      (cmd_s),
        .in_busy  (in_busy),
        .out_full (out_valid)
    );

    sem_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_cmd   (cmd),
        .in_pix   ({pix_red, pix_green, pix_blue}),
        .cmd      (cmd_s),
        .status   (status_s),
        .edges    (edges),
        .last     (frame_last)
    );

    assign edge_blue  = edges[7:0];
    assign edge_green = edges[15:8];
    assign edge_red   = edges[23:16];
endmodule

// ----- design/sem_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the Sobel block, bound to the top level.
// Depends on sobel_edge_magnitude_rgb ports only.
module sem_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [7:0] edge_red
);
    // one word in flight: no input taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken with result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(edge_red))
        else $error("result dropped");
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("back to back take");
endmodule

bind sobel_edge_magnitude_rgb sem_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .edge_red(edge_red)
);
